### hdl/fire_effect_frame_engine_defines.svh
// Assertion macros for the fire effect frame engine checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FIRE_EFFECT_FRAME_ENGINE_DEFINES_SVH
`define FIRE_EFFECT_FRAME_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FEFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FEFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/fefe_pkg.sv
// Shared types, constants and the palette function of the fire effect engine.
// No dependencies.
`timescale 1ns / 1ps
package fefe_pkg;

  localparam int FRAME_WIDTH  = 132;
  localparam int FRAME_HEIGHT = 176;

  localparam int IDX_W      = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAT_BOOST = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIND       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLES      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 8'd3;

  // generator and remainder-by-100 constants
  localparam logic [31:0] LCG_MULT  = 32'h0808_8405;
  localparam logic [31:0] MOD_MAGIC = 32'h51EB_851F;  // ceil(2^37 / 100)
  localparam int          MOD_SHIFT = 37;
  localparam logic [31:0] RAND_MOD  = 32'd100;
  localparam logic [7:0]  HEAT_BASE = 8'd155;
  localparam logic [8:0]  HEAT_MAX  = 9'd255;
  localparam logic [20:0] THIRD_MUL = 21'd683;        // ~2^11 / 3
  localparam int          THIRD_SH  = 11;

  // request codes
  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_BOT_LCG,
    ST_BOT_DIV,
    ST_BOT_MOD,
    ST_PX_TAP,
    ST_PX_LAST,
    ST_PX_CALC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // black-red-yellow-white ramp; values from 252 up give black
  function automatic rgba_t palette(input logic [7:0] v);
    rgba_t      c;
    logic [9:0] t;
    c = '0;
    t = '0;
    if (v < 8'd84) begin
      t = 10'(v) * 10'd3;
      c.red = t[7:0];
    end else if (v < 8'd168) begin
      t = 10'(v - 8'd84) * 10'd3;
      c.red   = 8'd249;
      c.green = t[7:0];
    end else if (v < 8'd252) begin
      t = 10'(v - 8'd168) * 10'd3;
      c.red   = 8'd249;
      c.green = 8'd249;
      c.blue  = t[7:0];
    end
    c.alpha = (v <= 8'd253) ? v + 8'd1 : 8'd0;
    return c;
  endfunction

endpackage

### hdl/fefe_ram.sv
// Generic single-port RAM with registered read.
// Depends on fefe_pkg for default sizes.
`timescale 1ns / 1ps
module fefe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = fefe_pkg::FRAME_WIDTH * fefe_pkg::FRAME_HEIGHT,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fire_effect_frame_engine.sv
// Read: an accepted request goes through ST_READ and ST_FINISH to the output
// register. Advance: W-2 bottom-row cells are seeded, then W*(H-3) pixels take
// the four-tap or wind rule, one neighbor read a cycle on the single RAM port.
// One request at a time; a finished word may wait at the output meanwhile.
// After reset a clearing pass zeroes all W*H cells (23232 by default) before
// the first request is taken; config writes work throughout.
`timescale 1ns / 1ps
module fire_effect_frame_engine #(
  parameter int FRAME_WIDTH  = fefe_pkg::FRAME_WIDTH,
  parameter int FRAME_HEIGHT = fefe_pkg::FRAME_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fefe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fefe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [fefe_pkg::IDX_W-1:0]      pixel_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  output logic [7:0]                      alpha_o,
  output logic                            frame_done_o
);

  localparam int N   = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW  = $clog2(N);
  localparam int SAW = AW + 2;
  localparam int XW  = $clog2(FRAME_WIDTH);
  localparam int YW  = $clog2(FRAME_HEIGHT);
  localparam int CW  = AW + fefe_pkg::IDX_W + 1;

  localparam logic signed [SAW-1:0] OFS_1W = SAW'(FRAME_WIDTH);
  localparam logic signed [SAW-1:0] OFS_2W = SAW'(2 * FRAME_WIDTH);
  localparam logic signed [SAW-1:0] OFS_3W = SAW'(3 * FRAME_WIDTH);
  localparam logic signed [SAW-1:0] N_S    = SAW'(N);

  // config and generator
  logic [7:0]        boost_q;
  logic signed [4:0] wind_q;
  logic              holes_q;
  logic [31:0]       gen_q, gen_d;

  // sequencer
  fefe_pkg::state_e state_q, state_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [XW-1:0]    x_q, x_d;
  logic [YW-1:0]    y_q, y_d;
  logic [1:0]       tap_q, tap_d, prev_tap_q, prev_tap_d;
  logic [10:0]      sum_q, sum_d;
  logic [7:0]       old_q, old_d;
  logic             rd_ok_q, rd_ok_d;
  logic [63:0]      prod_q, prod_d;
  fefe_pkg::rgba_t  res_q, res_d;
  logic             res_done_q, res_done_d;

  // output register
  logic            out_valid_q, out_valid_d;
  fefe_pkg::rgba_t out_q, out_d;
  logic            out_done_q, out_done_d;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // shared datapath pieces
  logic [31:0]           mul_b;
  logic [63:0]           mul_p;
  logic                  far_row, wind_mode;
  logic [1:0]            last_tap;
  logic signed [SAW-1:0] tap_ofs, tap_sa;
  logic                  tap_ok;
  logic [7:0]            tap_data;
  logic [20:0]           third_p;
  logic [8:0]            new_v;
  logic [7:0]            settled;
  logic [CW-1:0]         idx_ext;
  logic                  idx_ok;
  logic [26:0]           quot;
  logic [31:0]           quot_x100, rem_full;
  logic                  out_free;
  logic                  accept;

  fefe_ram #(
    .WIDTH (8),
    .DEPTH (N)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != fefe_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // shared multiplier: generator step or reciprocal for the remainder
  assign mul_b = (state_q == fefe_pkg::ST_BOT_LCG) ? fefe_pkg::LCG_MULT : fefe_pkg::MOD_MAGIC;
  assign mul_p = 64'(gen_q) * 64'(mul_b);

  assign quot      = prod_q[63:fefe_pkg::MOD_SHIFT];
  assign quot_x100 = 32'(quot) * fefe_pkg::RAND_MOD;
  assign rem_full  = gen_q - quot_x100;

  // row rule select
  assign far_row   = (y_q < YW'(FRAME_HEIGHT - 3));
  assign wind_mode = far_row && (wind_q != 5'sd0);
  assign last_tap  = wind_mode ? 2'd2 : 2'd3;

  // neighbor offset; tap 1 is always the pixel itself
  always_comb begin
    tap_ofs = '0;
    if (wind_mode) begin
      case (tap_q)
        2'd0:    tap_ofs = OFS_2W - SAW'(wind_q);
        2'd2:    tap_ofs = OFS_2W;
        default: tap_ofs = '0;
      endcase
    end else begin
      case (tap_q)
        2'd0:    tap_ofs = (far_row ? OFS_3W : OFS_1W) - SAW'(1);
        2'd2:    tap_ofs = far_row ? OFS_3W : OFS_1W;
        2'd3:    tap_ofs = (far_row ? OFS_3W : OFS_1W) + SAW'(1);
        default: tap_ofs = '0;
      endcase
    end
  end

  assign tap_sa   = $signed({2'b00, addr_q}) + tap_ofs;
  assign tap_ok   = (tap_sa >= 0) && (tap_sa < N_S);
  assign tap_data = rd_ok_q ? ram_rdata : 8'd0;

  // divide by 3 or 4, then hole rule and saturation
  assign third_p = 21'(sum_q) * fefe_pkg::THIRD_MUL;
  assign new_v   = wind_mode ? third_p[fefe_pkg::THIRD_SH +: 9] : sum_q[10:2];
  always_comb begin
    if (holes_q && (new_v == 9'(old_q))) begin
      settled = 8'd0;
    end else if (new_v > fefe_pkg::HEAT_MAX) begin
      settled = 8'hFF;
    end else begin
      settled = new_v[7:0];
    end
  end

  assign idx_ext = CW'(pixel_index_i);
  assign idx_ok  = idx_ext < CW'(N);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fefe_pkg::ST_CLEAR: begin
        if (addr_q == AW'(N - 1)) state_d = fefe_pkg::ST_IDLE;
      end
      fefe_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (req_type_i == fefe_pkg::REQ_READ) ? fefe_pkg::ST_READ
                                                       : fefe_pkg::ST_BOT_LCG;
        end
      end
      fefe_pkg::ST_READ:    state_d = fefe_pkg::ST_FINISH;
      fefe_pkg::ST_BOT_LCG: state_d = fefe_pkg::ST_BOT_DIV;
      fefe_pkg::ST_BOT_DIV: state_d = fefe_pkg::ST_BOT_MOD;
      fefe_pkg::ST_BOT_MOD: begin
        state_d = (x_q == XW'(FRAME_WIDTH - 2)) ? fefe_pkg::ST_PX_TAP : fefe_pkg::ST_BOT_LCG;
      end
      fefe_pkg::ST_PX_TAP: begin
        if (tap_q == last_tap) state_d = fefe_pkg::ST_PX_LAST;
      end
      fefe_pkg::ST_PX_LAST: state_d = fefe_pkg::ST_PX_CALC;
      fefe_pkg::ST_PX_CALC: begin
        if (x_q == XW'(FRAME_WIDTH - 1) && y_q == YW'(2)) begin
          state_d = fefe_pkg::ST_FINISH;
        end else begin
          state_d = fefe_pkg::ST_PX_TAP;
        end
      end
      fefe_pkg::ST_FINISH: begin
        if (out_free) state_d = fefe_pkg::ST_IDLE;
      end
      default: state_d = fefe_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    gen_d       = gen_q;
    addr_d      = addr_q;
    x_d         = x_q;
    y_d         = y_q;
    tap_d       = tap_q;
    prev_tap_d  = prev_tap_q;
    sum_d       = sum_q;
    old_d       = old_q;
    rd_ok_d     = rd_ok_q;
    prod_d      = prod_q;
    res_d       = res_q;
    res_done_d  = res_done_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    out_done_d  = out_done_q;
    ram_we      = 1'b0;
    ram_addr    = addr_q;
    ram_wdata   = 8'd0;
    unique case (state_q)
      fefe_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        addr_d = addr_q + AW'(1);
      end
      fefe_pkg::ST_IDLE: begin
        ram_addr = idx_ext[AW-1:0];
        rd_ok_d  = idx_ok;
        x_d      = XW'(1);
        addr_d   = AW'((FRAME_HEIGHT - 1) * FRAME_WIDTH + 1);
      end
      fefe_pkg::ST_READ: begin
        res_d      = fefe_pkg::palette(rd_ok_q ? ram_rdata : 8'd0);
        res_done_d = 1'b0;
      end
      fefe_pkg::ST_BOT_LCG: begin
        gen_d = mul_p[31:0] + 32'd1;
      end
      fefe_pkg::ST_BOT_DIV: begin
        prod_d = mul_p;
      end
      fefe_pkg::ST_BOT_MOD: begin
        ram_we    = 1'b1;
        ram_wdata = 8'(rem_full[6:0]) + fefe_pkg::HEAT_BASE;
        tap_d     = 2'd0;
        if (x_q == XW'(FRAME_WIDTH - 2)) begin
          x_d    = '0;
          y_d    = YW'(FRAME_HEIGHT - 2);
          addr_d = AW'((FRAME_HEIGHT - 2) * FRAME_WIDTH);
        end else begin
          x_d    = x_q + XW'(1);
          addr_d = addr_q + AW'(1);
        end
      end
      fefe_pkg::ST_PX_TAP: begin
        // issue this tap, fold in the one read last cycle
        ram_addr   = tap_sa[AW-1:0];
        rd_ok_d    = tap_ok;
        prev_tap_d = tap_q;
        tap_d      = tap_q + 2'd1;
        if (tap_q == 2'd0) begin
          sum_d = 11'(boost_q);
        end else begin
          sum_d = sum_q + 11'(tap_data);
          if (prev_tap_q == 2'd1) old_d = ram_rdata;
        end
      end
      fefe_pkg::ST_PX_LAST: begin
        sum_d = sum_q + 11'(tap_data);
        if (prev_tap_q == 2'd1) old_d = ram_rdata;
      end
      fefe_pkg::ST_PX_CALC: begin
        ram_we    = 1'b1;
        ram_wdata = settled;
        tap_d     = 2'd0;
        if (x_q == XW'(FRAME_WIDTH - 1)) begin
          x_d    = '0;
          y_d    = y_q - YW'(1);
          addr_d = addr_q - AW'(2 * FRAME_WIDTH - 1);
        end else begin
          x_d    = x_q + XW'(1);
          addr_d = addr_q + AW'(1);
        end
        res_d      = '0;
        res_done_d = 1'b1;
      end
      fefe_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          out_done_d  = res_done_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fefe_pkg::ST_CLEAR;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      boost_q     <= 8'd0;
      wind_q      <= 5'sd0;
      holes_q     <= 1'b1;
      gen_q       <= 32'd0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
      // a seed write loads the generator
      gen_q       <= (cfg_we_i && (cfg_idx_i == fefe_pkg::CFG_SEED)) ? cfg_data_i : gen_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fefe_pkg::CFG_HEAT_BOOST: boost_q <= cfg_data_i[7:0];
          fefe_pkg::CFG_WIND:       wind_q  <= $signed(cfg_data_i[4:0]);
          fefe_pkg::CFG_HOLES:      holes_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    tap_q      <= tap_d;
    prev_tap_q <= prev_tap_d;
    sum_q      <= sum_d;
    old_q      <= old_d;
    rd_ok_q    <= rd_ok_d;
    prod_q     <= prod_d;
    res_q      <= res_d;
    res_done_q <= res_done_d;
    out_q      <= out_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o  = out_valid_q;
  assign red_o        = out_q.red;
  assign green_o      = out_q.green;
  assign blue_o       = out_q.blue;
  assign alpha_o      = out_q.alpha;
  assign frame_done_o = out_done_q;

endmodule

### hdl/fefe_checker.sv
// Port-level checks for the fire effect frame engine, bound to the top level.
// Depends on fire_effect_frame_engine_defines.svh.
`timescale 1ns / 1ps
`include "fire_effect_frame_engine_defines.svh"
module fefe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic [7:0] alpha_o,
  input logic       frame_done_o
);

  // a stalled word stays valid and keeps its red, alpha and done bits
  `FEFE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(red_o) && $stable(alpha_o) && $stable(frame_done_o), "stalled output word changed")

  // an accepted request keeps the engine busy next cycle
  `FEFE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input taken again right after accept")

  // advance answers carry no color
  `FEFE_ASSERT_NOW(a_advance_blank, out_valid_o && frame_done_o, red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0 && alpha_o == 8'd0, "advance word not blank")

  // below full red only the red channel is lit
  `FEFE_ASSERT_NOW(a_palette_red, out_valid_o && !frame_done_o && red_o != 8'd249, green_o == 8'd0 && blue_o == 8'd0, "palette ramp broken")

endmodule

bind fire_effect_frame_engine fefe_checker u_fefe_checker (.*);
